// ----- design/psm_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and codes for the page slot memory map
package psm_pkg;

  // address space and page geometry
  localparam int ADDR_BITS  = 20;
  localparam int PAGE_BITS  = 12;
  localparam int SLOT_BITS  = ADDR_BITS - PAGE_BITS;
  localparam int SLOT_COUNT = 1 << SLOT_BITS;
  localparam int CNT_BITS   = SLOT_BITS + 1;
  localparam int LEN_BITS   = ADDR_BITS + 1;
  localparam int SUM_BITS   = LEN_BITS + 1;
  localparam int ID_BITS    = 4;
  localparam int STAT_BITS  = 3;
  localparam int FILL_BITS  = 16;

  // queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // fill data for unmapped reads
  localparam logic [FILL_BITS-1:0] FILL_WORD = 16'hF00F;
  localparam logic [FILL_BITS-1:0] FILL_BYTE = 16'h000F;

  // opcodes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_MAP    = 2'd2;
  localparam logic [1:0] OP_ACCESS = 2'd3;

  // status codes
  localparam logic [STAT_BITS-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_LEN_ALIGN = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_SRC_ALIGN = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_WIN_ALIGN = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_SRC_RANGE = 3'd4;
  localparam logic [STAT_BITS-1:0] ST_WIN_RANGE = 3'd5;

  // work kinds handed from front to back
  typedef enum logic [2:0] {
    JOB_DONE,
    JOB_ALLOC,
    JOB_FREE,
    JOB_MAP,
    JOB_ACCESS
  } job_kind_t;

  // incoming item
  typedef struct packed {
    logic [1:0]           opcode;
    logic [ID_BITS-1:0]   block_number;
    logic [ADDR_BITS-1:0] address;
    logic [ADDR_BITS-1:0] window_address;
    logic [LEN_BITS-1:0]  length;
    logic                 word_access;
    logic                 is_write;
  } request_t;

  // outgoing item
  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic                 replaced;
    logic                 mapped;
    logic [ID_BITS-1:0]   hit_block;
    logic [ADDR_BITS-1:0] offset;
    logic [FILL_BITS-1:0] fill_value;
  } result_t;

  // classified item in the queue
  typedef struct packed {
    job_kind_t            kind;
    logic [STAT_BITS-1:0] status;
    logic [ID_BITS-1:0]   id;
    logic [SLOT_BITS-1:0] src_slot;
    logic [SLOT_BITS-1:0] dst_slot;
    logic [CNT_BITS-1:0]  count;
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] shift;
    logic                 word_access;
    logic                 is_write;
  } job_t;

  // one page slot entry
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [ADDR_BITS-1:0] base;
  } slot_t;

endpackage

// ----- design/psm_front.sv -----
`timescale 1ns / 1ps
// front end: accepts items, checks alignment and range, builds queue entries
module psm_front (
  input  logic              start,
  input  logic              busy,
  input  psm_pkg::request_t request,
  output logic              push,
  output psm_pkg::job_t     job
);
  import psm_pkg::*;

  localparam logic [SUM_BITS-1:0] SPACE_SIZE = SUM_BITS'(SLOT_COUNT) << PAGE_BITS;

  logic [SUM_BITS-1:0]  src_end;
  logic [SUM_BITS-1:0]  win_end;
  logic                 src_ok;
  logic                 win_ok;
  logic [SLOT_BITS-1:0] first_slot;
  logic [SLOT_BITS-1:0] win_slot;
  logic [CNT_BITS-1:0]  len_pages;
  logic [CNT_BITS-1:0]  room;
  logic [CNT_BITS-1:0]  alloc_count;

  // range checks: non-empty and last byte inside the space
  assign src_end = SUM_BITS'(request.address) + SUM_BITS'(request.length);
  assign win_end = SUM_BITS'(request.window_address) + SUM_BITS'(request.length);
  assign src_ok  = (request.length != '0) && (src_end <= SPACE_SIZE);
  assign win_ok  = (request.length != '0) && (win_end <= SPACE_SIZE);

  // page numbers and slot counts
  assign first_slot  = request.address[ADDR_BITS-1:PAGE_BITS];
  assign win_slot    = request.window_address[ADDR_BITS-1:PAGE_BITS];
  assign len_pages   = request.length[LEN_BITS-1:PAGE_BITS];
  assign room        = CNT_BITS'(SLOT_COUNT) - CNT_BITS'(first_slot);
  assign alloc_count = (len_pages < room) ? len_pages : room;

  assign push = start & ~busy;

  // classify the item
  always_comb begin
    job        = '0;
    job.kind   = JOB_DONE;
    job.status = ST_OK;
    case (request.opcode)
      OP_ALLOC: begin
        if (!src_ok) begin
          job.status = ST_SRC_RANGE;
        end else if (alloc_count != '0) begin
          job.kind     = JOB_ALLOC;
          job.id       = request.block_number;
          job.src_slot = first_slot;
          job.dst_slot = first_slot;
          job.count    = alloc_count;
          job.base     = request.address;
        end
      end
      OP_FREE: begin
        job.kind  = JOB_FREE;
        job.id    = request.block_number;
        job.count = CNT_BITS'(SLOT_COUNT);
      end
      OP_MAP: begin
        if (request.length[PAGE_BITS-1:0] != '0) begin
          job.status = ST_LEN_ALIGN;
        end else if (request.address[PAGE_BITS-1:0] != '0) begin
          job.status = ST_SRC_ALIGN;
        end else if (request.window_address[PAGE_BITS-1:0] != '0) begin
          job.status = ST_WIN_ALIGN;
        end else if (!src_ok) begin
          job.status = ST_SRC_RANGE;
        end else if (!win_ok) begin
          job.status = ST_WIN_RANGE;
        end else begin
          job.kind     = JOB_MAP;
          job.src_slot = first_slot;
          job.dst_slot = win_slot;
          job.count    = len_pages;
          job.shift    = request.window_address - request.address;
        end
      end
      default: begin
        job.kind        = JOB_ACCESS;
        job.src_slot    = first_slot;
        job.base        = request.address;
        job.word_access = request.word_access;
        job.is_write    = request.is_write;
      end
    endcase
  end

endmodule

// ----- design/psm_queue.sv -----
`timescale 1ns / 1ps
// short queue of classified items between front and back
module psm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  psm_pkg::job_t job_in,
  input  logic          pop,
  output psm_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  import psm_pkg::*;

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;

  // pointers and fill level, pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= job_in;
  end

  assign head  = entries[rd_ptr];
  assign empty = (fill == '0);
  assign full  = (fill == (QPTR_BITS + 1)'(QUEUE_DEPTH));

endmodule

// ----- design/psm_back.sv -----
`timescale 1ns / 1ps
// back end: slot table, slot walks for allocate, free and map, access lookup
module psm_back (
  input  logic             clk,
  input  logic             rst,
  input  psm_pkg::job_t    head,
  input  logic             empty,
  output logic             pop,
  output logic             done,
  output psm_pkg::result_t result
);
  import psm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE
  } state_t;

  state_t state;

  // slot table and per-slot written flags
  slot_t                 mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;
  slot_t                 rd_data;
  logic                  rd_valid;
  logic                  rd_en;
  logic [SLOT_BITS-1:0]  rd_addr;
  logic                  wr_en;
  slot_t                 wr_data;
  logic                  clear_en;
  slot_t                 eff;

  // walk registers
  job_kind_t             walk_kind;
  logic [ID_BITS-1:0]    walk_id;
  logic [ADDR_BITS-1:0]  walk_base;
  logic [ADDR_BITS-1:0]  walk_shift;
  logic [SLOT_BITS-1:0]  rd_idx;
  logic [SLOT_BITS-1:0]  wr_idx;
  logic [CNT_BITS-1:0]   remain;
  logic                  walk_replaced;
  logic                  last;
  logic                  hit_old;

  // result stage
  logic                  pend_valid;
  logic                  pend_access;
  logic [STAT_BITS-1:0]  pend_status;
  logic                  pend_replaced;
  logic [ADDR_BITS-1:0]  pend_addr;
  logic                  pend_word;
  logic                  pend_write;
  result_t               result_next;

  assign pop     = (state == S_IDLE) && !empty;
  assign rd_en   = (pop && (head.kind == JOB_ACCESS)) || (state == S_READ);
  assign rd_addr = (state == S_READ) ? rd_idx : head.src_slot;

  // a slot never written since reset reads as empty
  assign eff     = rd_valid ? rd_data : slot_t'('0);
  assign last    = (remain == CNT_BITS'(1));
  assign hit_old = (walk_kind == JOB_ALLOC) && (eff.id != '0);

  // write side of the walk
  always_comb begin
    wr_en    = 1'b0;
    wr_data  = '0;
    clear_en = 1'b0;
    if (state == S_WRITE) begin
      case (walk_kind)
        JOB_ALLOC: begin
          wr_en        = 1'b1;
          wr_data.id   = walk_id;
          wr_data.base = walk_base;
        end
        JOB_MAP: begin
          wr_en        = 1'b1;
          wr_data.id   = eff.id;
          wr_data.base = eff.base + walk_shift;
        end
        default: begin
          clear_en = (eff.id == walk_id);
        end
      endcase
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= slot_valid[rd_addr];
    end
  end

  // written flags, cleared together at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[wr_idx] <= 1'b1;
    end else if (clear_en) begin
      slot_valid[wr_idx] <= 1'b0;
    end
  end

  // result formatting from the result stage
  always_comb begin
    result_next = '0;
    if (pend_access) begin
      if (eff.id != '0) begin
        result_next.mapped    = 1'b1;
        result_next.hit_block = eff.id;
        result_next.offset    = pend_addr - eff.base;
      end else if (!pend_write) begin
        result_next.fill_value = pend_word ? FILL_WORD : FILL_BYTE;
      end
    end else begin
      result_next.status   = pend_status;
      result_next.replaced = pend_replaced;
    end
  end

  // sequencer, result stage and output register
  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= pend_valid;
      pend_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.kind)
              JOB_ALLOC, JOB_FREE, JOB_MAP: begin
                state         <= S_READ;
                walk_kind     <= head.kind;
                walk_id       <= head.id;
                walk_base     <= head.base;
                walk_shift    <= head.shift;
                rd_idx        <= head.src_slot;
                wr_idx        <= head.dst_slot;
                remain        <= head.count;
                walk_replaced <= 1'b0;
              end
              JOB_ACCESS: begin
                pend_valid  <= 1'b1;
                pend_access <= 1'b1;
                pend_addr   <= head.base;
                pend_word   <= head.word_access;
                pend_write  <= head.is_write;
              end
              default: begin
                pend_valid    <= 1'b1;
                pend_access   <= 1'b0;
                pend_status   <= head.status;
                pend_replaced <= 1'b0;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          rd_idx <= rd_idx + 1'b1;
          wr_idx <= wr_idx + 1'b1;
          remain <= remain - 1'b1;
          if (hit_old) walk_replaced <= 1'b1;
          if (last) begin
            state         <= S_IDLE;
            pend_valid    <= 1'b1;
            pend_access   <= 1'b0;
            pend_status   <= ST_OK;
            pend_replaced <= walk_replaced | hit_old;
          end else begin
            state <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/page_slot_memory_map_core.sv -----
`timescale 1ns / 1ps
// top level of the page slot memory map
//
// Command channel: an item (request) is taken at a rising edge with start high
// and busy low. busy rises while the two-entry queue between the front and the
// back end is full. Result channel: done marks each result for exactly one
// cycle, one result per item, in item order; the receiver cannot hold it off.
// Path: an item taken into an empty block passes the queue entry, the
// result stage and the output register before done rises with its result.
// Accesses and rejected requests stream at one item per cycle, limited by
// the single read port of the slot table. Allocate and map walk their page
// slots with a read then a write on the table for each slot; free walks
// all 256 slots. Later items queue behind a walk.
// Reset: every slot reads as empty straight away (per-slot written flags are
// cleared together), the queue empties, done drops; no clearing pass.
module page_slot_memory_map_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psm_pkg::request_t request,
  output logic              done,
  output psm_pkg::result_t  result
);
  import psm_pkg::*;

  logic push;
  job_t job;
  job_t head;
  logic pop;
  logic empty;
  logic full;

  assign busy = full;

  // classify incoming items
  psm_front u_front (
    .start   (start),
    .busy    (busy),
    .request (request),
    .push    (push),
    .job     (job)
  );

  // decouple front and back
  psm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  // carry out the work on the slot table
  psm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

// ----- design/psm_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the page slot memory map, bound to the top level
module psm_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input psm_pkg::request_t request,
  input logic              done,
  input psm_pkg::result_t  result
);
  import psm_pkg::*;

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // queue only fills through an accepted item
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

  // a mapped access carries a block id and no fill or fault
  a_mapped: assert property (@(posedge clk) disable iff (rst)
    (done && result.mapped) |->
      (result.hit_block != '0 && result.fill_value == '0 && result.status == ST_OK
       && !result.replaced))
    else $error("inconsistent mapped result");

  // a fault carries nothing else
  a_fault: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (!result.replaced && !result.mapped && result.offset == '0
       && result.fill_value == '0 && result.status <= ST_WIN_RANGE))
    else $error("inconsistent fault result");

endmodule

bind page_slot_memory_map_core psm_checker u_checker (.*);

// ----- tb/psm_checker.sv -----
`timescale 1ns / 1ps
// checker for the page slot memory map: predicts every result and compares
module psm_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  psm_pkg::request_t request,
  input  logic              done,
  input  psm_pkg::result_t  result,
  output int                failures,
  output int                pending,
  output int                checked
);
  import psm_pkg::*;

  // own copy of the page slot table
  logic [ID_BITS-1:0]   slot_id   [SLOT_COUNT];
  logic [ADDR_BITS-1:0] slot_base [SLOT_COUNT];

  // predicted results, oldest first
  result_t outcome_q [$];
  result_t want;

  // a span of len bytes from lo lies inside the address space
  function automatic bit span_fits(input longint unsigned lo, input longint unsigned len);
    return len != 0 && lo + len - 1 < (64'd1 << ADDR_BITS);
  endfunction

  // works out the result of one item and updates the table
  function automatic result_t map_outcome(input request_t r);
    result_t              res;
    int                   first, n, dst_pg, k;
    logic [ADDR_BITS-1:0] shift, a;
    res    = '0;
    first  = int'(r.address[ADDR_BITS-1:PAGE_BITS]);
    dst_pg = int'(r.window_address[ADDR_BITS-1:PAGE_BITS]);
    n      = int'(r.length[LEN_BITS-1:PAGE_BITS]);
    case (r.opcode)
      OP_ALLOC: begin
        // whole pages only, starting at the page of the base
        if (!span_fits(64'(r.address), 64'(r.length))) begin
          res.status = ST_SRC_RANGE;
        end else begin
          for (k = first; k < first + n && k < SLOT_COUNT; k++) begin
            if (slot_id[k] != '0) res.replaced = 1'b1;
            slot_id[k]   = r.block_number;
            slot_base[k] = r.address;
          end
        end
      end
      OP_FREE: begin
        foreach (slot_id[k]) begin
          if (slot_id[k] == r.block_number) begin
            slot_id[k]   = '0;
            slot_base[k] = '0;
          end
        end
      end
      OP_MAP: begin
        // checks in fixed priority, then an ascending copy
        if (r.length[PAGE_BITS-1:0] != '0) res.status = ST_LEN_ALIGN;
        else if (r.address[PAGE_BITS-1:0] != '0) res.status = ST_SRC_ALIGN;
        else if (r.window_address[PAGE_BITS-1:0] != '0) res.status = ST_WIN_ALIGN;
        else if (!span_fits(64'(r.address), 64'(r.length))) res.status = ST_SRC_RANGE;
        else if (!span_fits(64'(r.window_address), 64'(r.length))) res.status = ST_WIN_RANGE;
        else begin
          shift = r.window_address - r.address;
          for (k = 0; k < n && first + k < SLOT_COUNT && dst_pg + k < SLOT_COUNT; k++) begin
            slot_id[dst_pg + k]   = slot_id[first + k];
            slot_base[dst_pg + k] = slot_base[first + k] + shift;
          end
        end
      end
      default: begin
        // access: only the page of the first byte is decoded
        a = r.address;
        k = int'(a[ADDR_BITS-1:PAGE_BITS]);
        if (slot_id[k] != '0) begin
          res.mapped    = 1'b1;
          res.hit_block = slot_id[k];
          res.offset    = a - slot_base[k];
        end else if (!r.is_write) begin
          res.fill_value = r.word_access ? FILL_WORD : FILL_BYTE;
        end
      end
    endcase
    return res;
  endfunction

  // one field of a result against its prediction
  function automatic void compare_field(input string field, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      failures++;
      if (failures <= 10)
        $display("result %0d, %s: expected 0x%0h, got 0x%0h", checked, field, exp_val,
                 got_val);
    end
  endfunction

  // watch both channels; results are checked before the new item is predicted
  always @(posedge clk) begin
    if (rst) begin
      outcome_q.delete();
      foreach (slot_id[k]) begin
        slot_id[k]   = '0;
        slot_base[k] = '0;
      end
      pending <= 0;
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          failures++;
          if (failures <= 10) $display("result with no item outstanding: %p", result);
        end else begin
          want = outcome_q.pop_front();
          compare_field("status", 32'(want.status), 32'(result.status));
          compare_field("replaced", 32'(want.replaced), 32'(result.replaced));
          compare_field("mapped", 32'(want.mapped), 32'(result.mapped));
          compare_field("hit_block", 32'(want.hit_block), 32'(result.hit_block));
          compare_field("offset", 32'(want.offset), 32'(result.offset));
          compare_field("fill_value", 32'(want.fill_value), 32'(result.fill_value));
          checked++;
        end
      end
      if (start && !busy) outcome_q.insert(outcome_q.size(), map_outcome(request));
      pending <= outcome_q.size();
    end
  end

endmodule

// ----- tb/tb_page_slot_memory_map_core.sv -----
`timescale 1ns / 1ps
// testbench top for the page slot memory map: stimulus, run limit and verdict
module tb_page_slot_memory_map_core;
  import psm_pkg::*;

  localparam int RANDOM_ITEMS = 680;
  localparam int QUIET_TAIL   = 120;
  localparam int DRAIN_LIMIT  = 5000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  request_t request;
  result_t  result;
  int       failures;
  int       pending;
  int       checked;
  int       op_count [4];
  int       drained;

  page_slot_memory_map_core dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  psm_scoreboard checker_i (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .failures (failures),
    .pending  (pending),
    .checked  (checked)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // builds one item from its fields
  function automatic request_t mk(input logic [1:0] op, input logic [ID_BITS-1:0] id,
                                  input logic [ADDR_BITS-1:0] addr,
                                  input logic [ADDR_BITS-1:0] win,
                                  input logic [LEN_BITS-1:0] len, input logic word,
                                  input logic wr);
    request_t r;
    r.opcode         = op;
    r.block_number   = id;
    r.address        = addr;
    r.window_address = win;
    r.length         = len;
    r.word_access    = word;
    r.is_write       = wr;
    return r;
  endfunction

  // page base, mostly among the first 32 pages so blocks get hit and moved
  function automatic logic [ADDR_BITS-1:0] hot_page();
    logic [ADDR_BITS-1:0] pg;
    if ($urandom_range(0, 3) != 0) pg = ADDR_BITS'($urandom_range(0, 31));
    else pg = ADDR_BITS'($urandom_range(0, SLOT_COUNT - 1));
    return pg << PAGE_BITS;
  endfunction

  // mostly well-formed operations with random content, the rest raw noise
  function automatic request_t random_item();
    request_t r;
    int       roll;
    r.opcode         = 2'($urandom);
    r.block_number   = ID_BITS'($urandom);
    r.address        = ADDR_BITS'($urandom);
    r.window_address = ADDR_BITS'($urandom);
    r.length         = LEN_BITS'($urandom);
    r.word_access    = 1'($urandom);
    r.is_write       = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      r.opcode = OP_ACCESS;
      if (roll < 38) r.address = hot_page() | (r.address & ADDR_BITS'(12'hFFF));
    end else if (roll < 68) begin
      r.opcode = OP_ALLOC;
      if (roll < 66) r.block_number = ID_BITS'($urandom_range(1, 15));
      r.address = hot_page();
      r.length  = LEN_BITS'($urandom_range(1, 6)) << PAGE_BITS;
      // partial page: unaligned base and length
      if (roll >= 63) begin
        r.address = r.address | ADDR_BITS'($urandom & 32'hFFF);
        r.length  = r.length | LEN_BITS'($urandom & 32'hFFF);
      end
    end else if (roll < 80) begin
      r.opcode         = OP_MAP;
      r.address        = hot_page();
      r.window_address = hot_page();
      if (roll < 78) r.length = LEN_BITS'($urandom_range(1, 4)) << PAGE_BITS;
    end else if (roll < 84) begin
      r.opcode       = OP_FREE;
      r.block_number = ID_BITS'($urandom_range(1, 15));
    end
    return r;
  endfunction

  // present one item and hold it until taken
  task automatic issue(input request_t item);
    start   <= 1'b1;
    request <= item;
    op_count[item.opcode]++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  // hold off until every outstanding result is back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // unmapped reads and writes on an empty table
    issue(mk(OP_ACCESS, 4'd0, 20'h00000, 20'h00000, 21'h0, 1'b0, 1'b0));
    issue(mk(OP_ACCESS, 4'd0, 20'hFFFFF, 20'h00000, 21'h0, 1'b1, 1'b0));
    issue(mk(OP_ACCESS, 4'd0, 20'h00123, 20'h00000, 21'h0, 1'b1, 1'b1));
    // allocate: plain, zero length, partial page, out of range, overwrite, id zero
    issue(mk(OP_ALLOC, 4'd15, 20'h00000, 20'h00000, 21'h03000, 1'b0, 1'b0));
    issue(mk(OP_ALLOC, 4'd7, 20'h40000, 20'h00000, 21'h00000, 1'b0, 1'b0));
    issue(mk(OP_ALLOC, 4'd3, 20'h10800, 20'h00000, 21'h01800, 1'b0, 1'b0));
    issue(mk(OP_ACCESS, 4'd0, 20'h10900, 20'h00000, 21'h0, 1'b0, 1'b0));
    issue(mk(OP_ALLOC, 4'd4, 20'hFF000, 20'h00000, 21'h02000, 1'b0, 1'b0));
    issue(mk(OP_ALLOC, 4'd5, 20'h01000, 20'h00000, 21'h01000, 1'b0, 1'b0));
    issue(mk(OP_ALLOC, 4'd0, 20'h02000, 20'h00000, 21'h01000, 1'b0, 1'b0));
    // map window: each rejection in turn
    issue(mk(OP_MAP, 4'd0, 20'h00000, 20'h20000, 21'h00800, 1'b0, 1'b0));
    issue(mk(OP_MAP, 4'd0, 20'h00010, 20'h20000, 21'h01000, 1'b0, 1'b0));
    issue(mk(OP_MAP, 4'd0, 20'h00000, 20'h20001, 21'h01000, 1'b0, 1'b0));
    issue(mk(OP_MAP, 4'd0, 20'h00000, 20'h20000, 21'h00000, 1'b0, 1'b0));
    issue(mk(OP_MAP, 4'd0, 20'hFF000, 20'h20000, 21'h02000, 1'b0, 1'b0));
    issue(mk(OP_MAP, 4'd0, 20'h00000, 20'hFF000, 21'h02000, 1'b0, 1'b0));
    // overlapping window copies ripple upwards, word read across a page
    issue(mk(OP_MAP, 4'd0, 20'h00000, 20'h01000, 21'h03000, 1'b0, 1'b0));
    issue(mk(OP_ACCESS, 4'd0, 20'h03FFF, 20'h00000, 21'h0, 1'b1, 1'b0));
    // window above the source shifts the base up, then a mapped write
    issue(mk(OP_MAP, 4'd0, 20'h10000, 20'hF0000, 21'h01000, 1'b0, 1'b0));
    issue(mk(OP_ACCESS, 4'd0, 20'hF0ABC, 20'h00000, 21'h0, 1'b0, 1'b1));
    // free a live id and id zero
    issue(mk(OP_FREE, 4'd15, 20'h00000, 20'h00000, 21'h0, 1'b0, 1'b0));
    issue(mk(OP_FREE, 4'd0, 20'h00000, 20'h00000, 21'h0, 1'b0, 1'b0));
    // whole space, then a length past the top
    issue(mk(OP_ALLOC, 4'd9, 20'h00000, 20'h00000, 21'h100000, 1'b0, 1'b0));
    issue(mk(OP_ACCESS, 4'd0, 20'hABCDE, 20'h00000, 21'h0, 1'b1, 1'b0));
    issue(mk(OP_ALLOC, 4'd2, 20'h00000, 20'h00000, 21'h1FFFFF, 1'b0, 1'b0));
    issue(mk(OP_FREE, 4'd9, 20'h00000, 20'h00000, 21'h0, 1'b0, 1'b0));
    wait_drained();

    // random traffic, one full drain midway, no gaps near the end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      issue(random_item());
      if (i == RANDOM_ITEMS / 2) wait_drained();
      else if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) idle_burst();
    end
    start <= 1'b0;

    // let the last results come back, then watch for strays
    drained = 0;
    do begin
      @(posedge clk);
      drained++;
    end while (pending != 0 && drained < DRAIN_LIMIT);
    repeat (10) @(posedge clk);
    if (pending != 0) $display("%0d results never arrived", pending);

    $display("%0d items sent: %0d allocate, %0d free, %0d map window, %0d access",
             op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[OP_ALLOC],
             op_count[OP_FREE], op_count[OP_MAP], op_count[OP_ACCESS]);
    $display("%0d results checked, %0d mismatches", checked, failures);
    if (failures == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
